### src/lwdc_pkg.sv
// lwdc_pkg: shared types and constants for the linear wet/dry crossfader
// depends on nothing; imported by lwdc_ctrl, lwdc_dp and the top level
`timescale 1ns / 1ps
`default_nettype none

package lwdc_pkg;

   // operation codes carried in the request beat
   typedef enum logic [1:0] {
      OP_MIX      = 2'd0,
      OP_RESET    = 2'd1,
      OP_ACTIVATE = 2'd2,
      OP_STATUS   = 2'd3
   } op_type;

   localparam int unsigned SAMPLE_W  = 16;
   localparam int unsigned COUNT_W   = 16;
   localparam int unsigned MIX_W     = COUNT_W + 1;   // mix spans 0 .. 65536
   localparam int unsigned DIV_STEPS = MIX_W;         // one quotient bit per step
   localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [COUNT_W-1:0] LEN_RESET = 16'd2048;

   typedef struct packed {
      op_type                     op;
      logic signed [SAMPLE_W-1:0] dry_sample;
      logic signed [SAMPLE_W-1:0] wet_sample;
      logic                       effect_enabled;
      logic                       end_of_frame;
      logic                       end_of_block;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] mixed_sample;
      logic                       wet_active;
      logic                       needs_wet;
      logic [COUNT_W-1:0]         frames_remaining;
      logic                       activated;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture the request beat, clear the divider
      logic div_step;   // one restoring divide step
      logic mul;        // register (wet - dry) * mix
      logic sum;        // add dry * 65536 and register the mixed sample
      logic commit;     // update ramp state and load the response register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic div_last;   // final quotient bit is being produced
      logic out_free;   // response register can take a beat this cycle
   } status_type;

endpackage

`default_nettype wire

### src/linear_wet_dry_crossfader.sv
// linear_wet_dry_crossfader: top level, controller plus datapath
// depends on lwdc_pkg, lwdc_ctrl and lwdc_dp
`timescale 1ns / 1ps
`default_nettype none

//  port group | direction | handshake          | beat
//  req_       | in        | req_valid/req_stall | lwdc_pkg::req_type
//  rsp_       | out       | rsp_valid/rsp_stall | lwdc_pkg::rsp_type
//  csr_       | in        | csr_write_enable    | transition_length, 16 bit
//
//  a mix beat (op 0) first runs the one-bit-per-cycle restoring divider that forms the
//  mix weight, then the multiply, sum and commit steps; the response is registered at commit,
//  and the next beat is taken on the cycle after commit
//  other ops skip the divider, multiplier and sum and go straight to commit
//  synchronous active-high reset: ramp count 0, wet flag clear, length 2048, no response
//  the response register is a separate stage, so a new beat is accepted while a finished
//  one waits under rsp_stall; only the commit cycle waits for that register to drain

module linear_wet_dry_crossfader (
   input  wire logic              clock,
   input  wire logic              reset,
   // request channel
   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire lwdc_pkg::req_type req_data,
   // response channel
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      lwdc_pkg::rsp_type rsp_data,
   // configuration
   input  wire logic              csr_write_enable,
   input  wire logic [15:0]       csr_write_data
);
   import lwdc_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       start_mix;

   // op 0 goes through the divider, everything else straight to commit
   assign start_mix = (req_data.op == OP_MIX);

   lwdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .start_mix (start_mix),
      .status    (status),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   lwdc_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_data         (req_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data)
   );

   // one beat in flight: an accepted beat blocks the request side next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while a beat is still in flight");

   // a response only appears out of the commit step
   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.commit))
      else $error("response valid rose without a commit");

   // commit never overwrites a response that is still stalled
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && rsp_valid) |-> !rsp_stall)
      else $error("commit while the response register is held");

   // a newly activated wet path always reports the flag set
   a_activated_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.activated) |-> (rsp_data.wet_active && rsp_data.needs_wet))
      else $error("activated reported without the wet flag set");

endmodule

`default_nettype wire

### src/lwdc_ctrl.sv
// lwdc_ctrl: sequencing state machine of the crossfader
// depends on lwdc_pkg; drives the command struct into lwdc_dp
`timescale 1ns / 1ps
`default_nettype none

module lwdc_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                start_mix,
   input  wire lwdc_pkg::status_type status,
   output      lwdc_pkg::cmd_type   cmd,
   output      logic                req_stall
);
   import lwdc_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_DIV  = 5'b00010,
      S_MUL  = 5'b00100,
      S_SUM  = 5'b01000,
      S_UPD  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = start_mix ? S_DIV : S_UPD;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_SUM;
         end
         S_SUM: begin
            cmd.sum  = 1'b1;
            state_in = S_UPD;
         end
         S_UPD: begin
            // wait for room in the response register
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### src/lwdc_dp.sv
// lwdc_dp: ramp state, length register, serial divider, multiplier and
// response register; depends on lwdc_pkg, steered by lwdc_ctrl commands
`timescale 1ns / 1ps
`default_nettype none

module lwdc_dp (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lwdc_pkg::cmd_type    cmd,
   output      lwdc_pkg::status_type status,
   input  wire lwdc_pkg::req_type    req_data,
   input  wire logic                 csr_write_enable,
   input  wire logic [15:0]          csr_write_data,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   output      lwdc_pkg::rsp_type    rsp_data
);
   import lwdc_pkg::*;

   // configuration and ramp state
   logic [COUNT_W-1:0] len_ff;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               flag_ff, flag_in;

   // captured request beat
   req_type            item_ff;

   // divider
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [COUNT_W-1:0]   rem_ff, rem_in;
   logic [MIX_W-1:0]     quo_ff, quo_in;

   // multiply and sum
   logic signed [MIX_W+MIX_W:0] prod_ff;
   logic signed [SAMPLE_W-1:0]  mixed_ff;

   // response register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic [COUNT_W-1:0] len_eff;
   logic [COUNT_W-1:0] count_clamp;
   logic [MIX_W-1:0]   trial;
   logic               trial_ge;

   logic signed [MIX_W-1:0]     diff_ws;
   logic signed [MIX_W:0]       mix_s;
   logic signed [MIX_W+MIX_W:0] acc;

   logic               needs_old;
   logic               act;
   logic [COUNT_W-1:0] remaining;

   assign len_eff     = (len_ff == '0) ? COUNT_W'(1) : len_ff;
   assign count_clamp = (count_ff > len_eff) ? len_eff : count_ff;

   // restoring divide of clamp(count) * 65536 by length, msb first
   assign trial    = (div_cnt_ff == '0) ? {1'b0, count_clamp} : {rem_ff, 1'b0};
   assign trial_ge = (trial >= {1'b0, len_eff});

   always_comb begin
      div_cnt_in = div_cnt_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      if (cmd.load) begin
         div_cnt_in = '0;
      end else if (cmd.div_step) begin
         div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
         rem_in     = trial_ge ? COUNT_W'(trial - {1'b0, len_eff}) : trial[COUNT_W-1:0];
         quo_in     = {quo_ff[MIX_W-2:0], trial_ge};
      end
   end

   assign status.div_last = (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));

   // dry*(65536-mix) + wet*mix = dry*65536 + (wet-dry)*mix
   assign diff_ws = {item_ff.wet_sample[SAMPLE_W-1], item_ff.wet_sample}
                  - {item_ff.dry_sample[SAMPLE_W-1], item_ff.dry_sample};
   assign mix_s   = signed'({1'b0, quo_ff});
   assign acc     = {{(MIX_W+MIX_W+1-SAMPLE_W-16){item_ff.dry_sample[SAMPLE_W-1]}},
                     item_ff.dry_sample, 16'd0} + prod_ff;

   // ramp update and response fields
   assign needs_old = item_ff.effect_enabled || (count_ff != '0);

   always_comb begin
      count_in = count_ff;
      flag_in  = flag_ff;
      act      = 1'b0;
      case (item_ff.op)
         OP_MIX: begin
            if (item_ff.end_of_frame) begin
               if (item_ff.effect_enabled) begin
                  if (count_ff < len_eff) begin
                     count_in = count_ff + COUNT_W'(1);
                  end
               end else if (count_ff != '0) begin
                  count_in = count_ff - COUNT_W'(1);
               end
            end
            if (item_ff.end_of_block && !item_ff.effect_enabled && (count_in == '0)) begin
               flag_in = 1'b0;
            end
         end
         OP_RESET: begin
            count_in = item_ff.effect_enabled ? len_eff : '0;
            flag_in  = item_ff.effect_enabled;
         end
         OP_ACTIVATE: begin
            if (needs_old && !flag_ff) begin
               flag_in = 1'b1;
               act     = 1'b1;
            end
         end
         OP_STATUS: begin
            count_in = count_ff;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_comb begin
      if (item_ff.effect_enabled) begin
         remaining = (count_in >= len_eff) ? '0 : len_eff - count_in;
      end else begin
         remaining = count_in;
      end
   end

   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_data_in                  = rsp_data_ff;
      rsp_valid_in                 = rsp_valid_ff && rsp_stall;
      if (cmd.commit) begin
         rsp_valid_in                 = 1'b1;
         rsp_data_in.mixed_sample     = (item_ff.op == OP_MIX) ? mixed_ff : '0;
         rsp_data_in.wet_active       = flag_in;
         rsp_data_in.needs_wet        = item_ff.effect_enabled || (count_in != '0);
         rsp_data_in.frames_remaining = remaining;
         rsp_data_in.activated        = act;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= LEN_RESET;
         count_ff     <= '0;
         flag_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         div_cnt_ff   <= '0;
      end else begin
         if (csr_write_enable) begin
            len_ff <= csr_write_data;
         end
         if (cmd.commit) begin
            count_ff <= count_in;
            flag_ff  <= flag_in;
         end
         rsp_valid_ff <= rsp_valid_in;
         div_cnt_ff   <= div_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_data;
      end
      if (cmd.mul) begin
         prod_ff <= diff_ws * mix_s;
      end
      if (cmd.sum) begin
         mixed_ff <= acc[16+SAMPLE_W-1:16];   // floor of acc / 65536
      end
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

### test/lwdc_result_checker.sv
// lwdc_result_checker: watches the request, response and csr ports of the crossfader,
// predicts every response beat and compares it field by field
// depends on lwdc_pkg for the beat types, operation codes and the reset length
`timescale 1ns / 1ps

module lwdc_result_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  lwdc_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  lwdc_pkg::rsp_type rsp_data,
   input  logic              csr_write_enable,
   input  logic [15:0]       csr_write_data,
   output int unsigned       results_owed,
   output int unsigned       error_count
);
   import lwdc_pkg::*;

   logic [15:0] fade_length;
   logic [15:0] ramp_count;
   logic        wet_flag;
   rsp_type     owed_beats[$];

   // one request beat: returns its response and moves the ramp state
   function automatic rsp_type step_crossfade(input req_type beat);
      rsp_type     r;
      logic [16:0] len;
      logic [16:0] clamped;
      logic [16:0] left;
      longint      mix_w;
      longint      acc;
      r   = '0;
      len = (fade_length == 16'd0) ? 17'd1 : {1'b0, fade_length};
      case (beat.op)
         OP_MIX: begin
            clamped = ({1'b0, ramp_count} > len) ? len : {1'b0, ramp_count};
            mix_w = (longint'(clamped) << 16) / longint'(len);
            acc = longint'($signed(beat.dry_sample)) * (64'sd65536 - mix_w)
                + longint'($signed(beat.wet_sample)) * mix_w;
            acc = acc >>> 16;
            r.mixed_sample = acc[15:0];
            if (beat.end_of_frame) begin
               if (beat.effect_enabled) begin
                  if ({1'b0, ramp_count} < len) ramp_count = ramp_count + 16'd1;
               end else if (ramp_count != 16'd0) begin
                  ramp_count = ramp_count - 16'd1;
               end
            end
            if (beat.end_of_block && !beat.effect_enabled && ramp_count == 16'd0)
               wet_flag = 1'b0;
         end
         OP_RESET: begin
            ramp_count = beat.effect_enabled ? len[15:0] : 16'd0;
            wet_flag   = beat.effect_enabled;
         end
         OP_ACTIVATE: begin
            if ((beat.effect_enabled || ramp_count != 16'd0) && !wet_flag) begin
               wet_flag    = 1'b1;
               r.activated = 1'b1;
            end
         end
         default: ;
      endcase
      r.wet_active = wet_flag;
      r.needs_wet  = beat.effect_enabled || ramp_count != 16'd0;
      left = len - {1'b0, ramp_count};
      if (!beat.effect_enabled) r.frames_remaining = ramp_count;
      else if ({1'b0, ramp_count} >= len) r.frames_remaining = 16'd0;
      else r.frames_remaining = left[15:0];
      return r;
   endfunction

   task automatic note_field(input string field, input int want_v, input int got_v);
      if (error_count < 10)
         $display("%0t rsp beat error: %s expected %0d got %0d", $time, field, want_v, got_v);
      error_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         fade_length = LEN_RESET;
         ramp_count  = '0;
         wet_flag    = 1'b0;
         owed_beats.delete();
      end else begin
         if (csr_write_enable) fade_length = csr_write_data;
         if (req_valid && !req_stall) owed_beats.push_back(step_crossfade(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (owed_beats.size() == 0) begin
               note_field("unrequested beat, mixed_sample", 0, int'(rsp_data.mixed_sample));
            end else begin
               want = owed_beats.pop_front();
               if (rsp_data.mixed_sample !== want.mixed_sample)
                  note_field("mixed_sample", int'(want.mixed_sample),
                             int'(rsp_data.mixed_sample));
               if (rsp_data.wet_active !== want.wet_active)
                  note_field("wet_active", int'(want.wet_active), int'(rsp_data.wet_active));
               if (rsp_data.needs_wet !== want.needs_wet)
                  note_field("needs_wet", int'(want.needs_wet), int'(rsp_data.needs_wet));
               if (rsp_data.frames_remaining !== want.frames_remaining)
                  note_field("frames_remaining", int'(want.frames_remaining),
                             int'(rsp_data.frames_remaining));
               if (rsp_data.activated !== want.activated)
                  note_field("activated", int'(want.activated), int'(rsp_data.activated));
            end
         end
      end
      results_owed = owed_beats.size();
   end

endmodule

### test/tb_linear_wet_dry_crossfader.sv
// tb_linear_wet_dry_crossfader: drives directed and random beats into the crossfader
// with random idling on both channels and reports the verdict
// depends on lwdc_pkg, linear_wet_dry_crossfader and lwdc_result_checker
`timescale 1ns / 1ps

module tb_linear_wet_dry_crossfader;
   import lwdc_pkg::*;

   // a mix beat, the send gaps, the stall bursts and the csr pause are all far shorter than
   // this limit, so this many quiet cycles means the block is stuck
   localparam int unsigned STALL_LIMIT   = 2000;
   localparam int unsigned RANDOM_PHASES = 10;
   localparam int unsigned PHASE_BEATS   = 153;
   localparam int          REQ_W         = $bits(req_type);

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_write_enable;
   logic [15:0] csr_write_data;

   int unsigned results_owed;
   int unsigned error_count;
   int unsigned quiet_cycles;
   bit          idling_on;
   bit          fx_on;

   linear_wet_dry_crossfader dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   lwdc_result_checker result_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .results_owed     (results_owed),
      .error_count      (error_count)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // watchdog: any beat accepted on either channel restarts the count
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // receiver side: random stall bursts while idling is on,
   // free-running stretches in between
   initial begin
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         if (idling_on && $urandom_range(0, 2) == 0) rsp_stall <= 1'b1;
         else rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
   end

   function automatic req_type make_beat(input op_type op, input logic [15:0] dry,
                                         input logic [15:0] wet, input logic en,
                                         input logic eof, input logic eob);
      req_type beat;
      beat.op             = op;
      beat.dry_sample     = dry;
      beat.wet_sample     = wet;
      beat.effect_enabled = en;
      beat.end_of_frame   = eof;
      beat.end_of_block   = eob;
      return beat;
   endfunction

   // full-scale and near-zero samples show up often, the rest is uniform
   function automatic logic [15:0] pick_sample();
      case ($urandom_range(0, 9))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         3:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // mostly mix beats with the effect switch held by the
   // caller; a share of control ops and some fully random noise beats
   function automatic req_type random_beat(input logic en);
      req_type          beat;
      logic [REQ_W-1:0] noise;
      int unsigned      roll;
      roll  = $urandom_range(0, 99);
      noise = REQ_W'({$urandom, $urandom});
      beat  = make_beat(OP_MIX, pick_sample(), pick_sample(), en,
                        1'($urandom_range(0, 1)), $urandom_range(0, 5) == 0);
      if (roll < 6) beat.op = OP_RESET;
      else if (roll < 14) beat.op = OP_ACTIVATE;
      else if (roll < 20) beat.op = OP_STATUS;
      else if (roll < 28) beat = noise;
      return beat;
   endfunction

   // called and returns at a falling edge; an optional gap drops valid first
   task automatic send_beat(input req_type beat);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // sender holds off until every owed response beat has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (results_owed != 0);
   endtask

   // csr writes only with the block idle, after a pause longer than a mix beat
   task automatic program_length(input logic [15:0] value);
      drain_results();
      repeat (25) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      logic [15:0] next_len;
      req_valid        = 1'b0;
      req_data         = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      reset            = 1'b1;
      idling_on        = 1'b1;
      fx_on            = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part at the reset length of 2048
      send_beat(make_beat(OP_STATUS,   16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0));
      // activate with nothing needing wet, then newly, then already set
      send_beat(make_beat(OP_ACTIVATE, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0));
      send_beat(make_beat(OP_ACTIVATE, 16'h0000, 16'h0000, 1'b1, 1'b0, 1'b0));
      send_beat(make_beat(OP_ACTIVATE, 16'h0000, 16'h0000, 1'b1, 1'b0, 1'b0));
      // pure dry at count zero, then one step up the ramp
      send_beat(make_beat(OP_MIX,      16'h8000, 16'h7FFF, 1'b1, 1'b1, 1'b0));
      send_beat(make_beat(OP_MIX,      16'h7FFF, 16'h8000, 1'b1, 1'b0, 1'b1));
      // jump to full ramp, pure wet with the count holding at the top, then one step down
      send_beat(make_beat(OP_RESET,    16'h0000, 16'h0000, 1'b1, 1'b0, 1'b0));
      send_beat(make_beat(OP_MIX,      16'h8000, 16'h7FFF, 1'b1, 1'b1, 1'b0));
      send_beat(make_beat(OP_MIX,      16'h0000, 16'hFFFF, 1'b0, 1'b1, 1'b0));
      send_beat(make_beat(OP_RESET,    16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0));
      send_beat(make_beat(OP_ACTIVATE, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0));
      // count above zero with the effect off still needs wet
      send_beat(make_beat(OP_MIX,      16'h7FFF, 16'h8000, 1'b1, 1'b1, 1'b0));
      send_beat(make_beat(OP_ACTIVATE, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0));
      // ramp back to zero at end of block clears the wet flag
      send_beat(make_beat(OP_MIX,      16'h8000, 16'h8000, 1'b0, 1'b1, 1'b1));
      send_beat(make_beat(OP_STATUS,   16'h0000, 16'h0000, 1'b1, 1'b0, 1'b0));

      // zero length behaves as one frame
      program_length(16'd0);
      send_beat(make_beat(OP_MIX,      16'h3039, 16'hA460, 1'b1, 1'b1, 1'b0));
      send_beat(make_beat(OP_MIX,      16'h3039, 16'hA460, 1'b1, 1'b0, 1'b0));
      send_beat(make_beat(OP_RESET,    16'h0000, 16'h0000, 1'b1, 1'b0, 1'b0));

      // longest ramp, jumped to the top
      program_length(16'hFFFF);
      send_beat(make_beat(OP_RESET,    16'h0000, 16'h0000, 1'b1, 1'b0, 1'b0));
      send_beat(make_beat(OP_MIX,      16'h8000, 16'h7FFF, 1'b1, 1'b0, 1'b1));

      // length lowered under the count: pure wet, count holds while enabled
      // and walks down while disabled
      program_length(16'd3);
      send_beat(make_beat(OP_MIX,      16'h7FFF, 16'h8000, 1'b1, 1'b1, 1'b0));
      send_beat(make_beat(OP_MIX,      16'h7FFF, 16'h8000, 1'b0, 1'b1, 1'b0));
      send_beat(make_beat(OP_STATUS,   16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0));

      program_length(16'd1);
      send_beat(make_beat(OP_RESET,    16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0));
      send_beat(make_beat(OP_MIX,      16'h8000, 16'h7FFF, 1'b1, 1'b1, 1'b0));

      // random part: short lengths let the counter sweep its whole range,
      // every third phase runs without idling and the last one never idles
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0:       next_len = 16'd2;
            1:       next_len = 16'd5;
            2:       next_len = 16'd1;
            3:       next_len = 16'd13;
            4:       next_len = 16'hFFFF;
            5:       next_len = 16'd0;
            6:       next_len = 16'($urandom_range(1, 40));
            7:       next_len = 16'd8;
            8:       next_len = 16'($urandom_range(1, 300));
            default: next_len = 16'd3;
         endcase
         program_length(next_len);
         idling_on = (p != RANDOM_PHASES - 1) && (p % 3 != 2);
         for (int n = 0; n < PHASE_BEATS; n++) begin
            if ($urandom_range(0, 23) == 0) fx_on = !fx_on;
            if ($urandom_range(0, 149) == 0) drain_results();
            send_beat(random_beat(fx_on));
         end
      end

      // let the last beats come back, then a short settle
      idling_on = 1'b0;
      drain_results();
      repeat (30) @(negedge clock);
      if (error_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

### linear_wet_dry_crossfader.f
src/lwdc_pkg.sv
src/lwdc_ctrl.sv
src/lwdc_dp.sv
src/linear_wet_dry_crossfader.sv
test/lwdc_result_checker.sv
test/tb_linear_wet_dry_crossfader.sv
